>>> design/kbn_pkg.sv
// Package for the keypoint box normalizer: payload types, codes, constants.
// Used by every module of the block; no dependencies.
`default_nettype none
package kbn_pkg;
    localparam int WORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int SCALE_BITS    = 31;
    localparam logic [SCALE_BITS-1:0] MIN_SCALE_RESET = 31'd655;

    localparam logic [1:0] KIND_FRAME = 2'd0;
    localparam logic [1:0] KIND_ROT   = 2'd1;
    localparam logic [1:0] KIND_KEY   = 2'd2;
    localparam logic [1:0] KIND_NONE  = 2'd3;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_SIZE     = 3'd1;
    localparam logic [2:0] ST_FOCAL    = 3'd2;
    localparam logic [2:0] ST_DEGEN    = 3'd3;
    localparam logic [2:0] ST_SAT      = 3'd4;
    localparam logic [2:0] ST_NO_FRAME = 3'd5;

    typedef struct packed {
        logic [1:0]  req_type;
        logic signed [WORD_BITS_DEF-1:0] word0;
        logic signed [WORD_BITS_DEF-1:0] word1;
        logic signed [WORD_BITS_DEF-1:0] word2;
        logic signed [WORD_BITS_DEF-1:0] word3;
        logic signed [WORD_BITS_DEF-1:0] word4;
        logic signed [WORD_BITS_DEF-1:0] word5;
        logic signed [WORD_BITS_DEF-1:0] word6;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic signed [WORD_BITS_DEF-1:0] out_a;
        logic signed [WORD_BITS_DEF-1:0] out_b;
        logic signed [WORD_BITS_DEF-1:0] out_c;
        logic [2:0]  status;
    } out_item_t;

    // handshake between sequencer and shared divider
    typedef struct packed {
        logic start;
    } div_ctl_t;
    typedef struct packed {
        logic done;
        logic sat;
    } div_sts_t;
endpackage
`default_nettype wire

>>> design/keypoint_box_normalizer_unit.sv
// Top level of the keypoint box normalizer: sequencer, box store, output register.
// Instantiates kbn_div and kbn_rot; uses kbn_pkg.
// Work per item: a frame runs three serial divides, a keypoint two, a rotation the kbn_rot test;
//   an item that fails its checks goes straight to the output register.
// Throughput: one item at a time; the shared one-bit-per-cycle divider sets the rate.
// Reset: rst_n asynchronous active low clears box_valid and control and sets min_scale to 655.
`default_nettype none
module keypoint_box_normalizer_unit
    import kbn_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire in_item_t              in_data,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output out_item_t                  out_data,
    input  wire logic                  cfg_we,
    input  wire logic [SCALE_BITS-1:0] cfg_wdata
);
    // word width is fixed by the payload structs
    localparam int WORD_BITS = WORD_BITS_DEF;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_DIV0 = 6'b000010,
        S_DIV1 = 6'b000100,
        S_DIV2 = 6'b001000,
        S_ROT  = 6'b010000,
        S_OUT  = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    in_item_t item_reg;
    logic [SCALE_BITS-1:0] min_scale_reg;
    logic signed [WORD_BITS-1:0] cx_reg, cy_reg, ext_reg;
    logic box_valid_reg;
    logic signed [WORD_BITS-1:0] ra_reg, rb_reg, rc_reg;
    logic sat_reg;
    logic [2:0] status_reg;
    logic ostart_reg;
    out_item_t out_reg;
    logic out_valid_reg;

    div_ctl_t dctl;
    div_sts_t dsts;
    logic signed [WORD_BITS+1:0] dnum;
    logic [WORD_BITS-1:0] dden;
    logic signed [WORD_BITS-1:0] dquo;
    logic rot_start, rot_done, rot_degen;

    logic in_acc;
    assign in_stall = state_reg != S_IDLE;
    assign in_acc = in_valid && !in_stall;

    // keypoint divisor floor and offsets
    logic [WORD_BITS-1:0] floor_v, scale_v;
    logic signed [WORD_BITS+1:0] dx, dy;
    logic outside;
    assign floor_v = (min_scale_reg == '0) ? WORD_BITS'(1) : WORD_BITS'(min_scale_reg);
    assign scale_v = ($signed(ext_reg) < $signed(floor_v)) ? floor_v : ext_reg;
    assign dx = ($signed((WORD_BITS+2)'(item_reg.word0)) - (WORD_BITS+2)'(cx_reg)) <<< 1;
    assign dy = ($signed((WORD_BITS+2)'(item_reg.word1)) - (WORD_BITS+2)'(cy_reg)) <<< 1;
    assign outside = dx < -$signed((WORD_BITS+2)'(ext_reg)) || dx > (WORD_BITS+2)'(ext_reg)
                  || dy < -$signed((WORD_BITS+2)'(ext_reg)) || dy > (WORD_BITS+2)'(ext_reg);

    // select divider operands per step
    always_comb
    begin
        dnum = '0;
        dden = WORD_BITS'(1);
        if (item_reg.req_type == KIND_FRAME)
        begin
            dden = item_reg.word3;
            case (state_reg)
                S_DIV0: dnum = (WORD_BITS+2)'(item_reg.word0) - (WORD_BITS+2)'(item_reg.word5);
                S_DIV1: dnum = (WORD_BITS+2)'(item_reg.word1) - (WORD_BITS+2)'(item_reg.word6);
                default: dnum = (WORD_BITS+2)'(item_reg.word2);
            endcase
        end
        else
        begin
            dden = scale_v;
            dnum = (state_reg == S_DIV0) ? dx : dy;
        end
    end

    // start the divider only in a divide step
    assign dctl.start = ostart_reg && state_reg != S_ROT;

    kbn_div #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div (
        .clk(clk), .rst_n(rst_n), .ctl(dctl), .num(dnum), .den(dden),
        .sts(dsts), .quo(dquo)
    );

    assign rot_start = ostart_reg && state_reg == S_ROT;
    kbn_rot #(.WORD_BITS(WORD_BITS)) u_rot (
        .clk(clk), .rst_n(rst_n), .start(rot_start),
        .a0(item_reg.word0), .a1(item_reg.word1), .a2(item_reg.word2),
        .b0(item_reg.word3), .b1(item_reg.word4), .b2(item_reg.word5),
        .done(rot_done), .degen(rot_degen)
    );

    // sequencer
    logic last_div;
    assign last_div = (state_reg == S_DIV2)
                   || (state_reg == S_DIV1 && item_reg.req_type == KIND_KEY);
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (in_acc)
                begin
                    case (in_data.req_type)
                        KIND_ROT: state_next = S_ROT;
                        KIND_FRAME:
                            state_next = (in_data.word2 <= 0 || in_data.word3 <= 0
                                          || in_data.word4 <= 0) ? S_OUT : S_DIV0;
                        KIND_KEY: state_next = box_valid_reg ? S_DIV0 : S_OUT;
                        default: state_next = S_IDLE;
                    endcase
                end
            S_DIV0: if (dsts.done) state_next = S_DIV1;
            S_DIV1: if (dsts.done) state_next = last_div ? S_OUT : S_DIV2;
            S_DIV2: if (dsts.done) state_next = S_OUT;
            S_ROT:  if (rot_done) state_next = S_OUT;
            S_OUT:  if (!out_valid_reg || !out_stall) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            min_scale_reg <= MIN_SCALE_RESET;
            box_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            ostart_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ostart_reg <= (state_next != state_reg) && state_next != S_OUT
                          && state_next != S_IDLE;
            if (cfg_we)
                min_scale_reg <= cfg_wdata;
            // store box once the frame passes its checks
            if (state_reg == S_DIV0 && dsts.done && item_reg.req_type == KIND_FRAME)
                box_valid_reg <= 1'b1;
            if (state_reg == S_OUT && (!out_valid_reg || !out_stall))
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            item_reg <= in_data;
            ra_reg <= '0; rb_reg <= '0; rc_reg <= '0;
            sat_reg <= 1'b0;
            if (in_data.req_type == KIND_FRAME && in_data.word2 <= 0)
                status_reg <= ST_SIZE;
            else if (in_data.req_type == KIND_FRAME
                     && (in_data.word3 <= 0 || in_data.word4 <= 0))
                status_reg <= ST_FOCAL;
            else if (in_data.req_type == KIND_KEY && !box_valid_reg)
                status_reg <= ST_NO_FRAME;
            else
                status_reg <= ST_OK;
        end
        if (state_reg == S_DIV0 && dsts.done && item_reg.req_type == KIND_FRAME)
        begin
            cx_reg  <= item_reg.word0;
            cy_reg  <= item_reg.word1;
            ext_reg <= item_reg.word2;
        end
        if (dsts.done)
        begin
            if (dsts.sat) sat_reg <= 1'b1;
            case (state_reg)
                S_DIV0: ra_reg <= dquo;
                S_DIV1: rb_reg <= dquo;
                S_DIV2: rc_reg <= dquo;
                default: ;
            endcase
            if (state_reg == S_DIV1 && item_reg.req_type == KIND_KEY)
                rc_reg <= outside ? '0 : item_reg.word2;
        end
        if (rot_done)
            status_reg <= rot_degen ? ST_DEGEN : ST_OK;
        if (state_reg == S_OUT && (!out_valid_reg || !out_stall))
        begin
            out_reg.result_kind <= item_reg.req_type;
            out_reg.out_a <= ra_reg;
            out_reg.out_b <= rb_reg;
            out_reg.out_c <= rc_reg;
            out_reg.status <= (status_reg == ST_OK && sat_reg) ? ST_SAT : status_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // a new transaction is only taken when the sequencer is idle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> state_reg != S_IDLE || $past(in_data.req_type) == KIND_NONE)
        else $error("accepted item did not start work");
    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");
    // divider completes only in a divide step
    assert property (@(posedge clk) disable iff (!rst_n)
        dsts.done |-> state_reg == S_DIV0 || state_reg == S_DIV1 || state_reg == S_DIV2)
        else $error("divider done outside a divide step");
endmodule
`default_nettype wire

>>> design/kbn_div.sv
// Shared iterative signed fixed-point divider: (n << FRAC) / d, d > 0.
// One quotient bit per cycle, truncating toward zero, saturating. Uses kbn_pkg.
`default_nettype none
module kbn_div
    import kbn_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire div_ctl_t                    ctl,
    input  wire logic signed [WORD_BITS+1:0] num,
    input  wire logic [WORD_BITS-1:0]        den,
    output div_sts_t                         sts,
    output logic signed [WORD_BITS-1:0]      quo
);
    localparam int NB = WORD_BITS + 2 + FRAC_BITS;
    localparam int CW = $clog2(NB + 1);

    logic [NB-1:0]        dvd_reg, dvd_next;
    logic [WORD_BITS:0]   rem_reg, rem_next;
    logic [WORD_BITS-1:0] den_reg, den_next;
    logic                 neg_reg, neg_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;

    logic [WORD_BITS+1:0] mag;
    logic [WORD_BITS+1:0] trial;
    logic [WORD_BITS:0]   shifted;
    logic [NB-1:0]        limit;

    assign mag   = num[WORD_BITS+1] ? (~num + 1'b1) : num;
    assign limit = neg_reg ? (NB'(1) << (WORD_BITS-1)) : ((NB'(1) << (WORD_BITS-1)) - 1'b1);
    assign shifted = {rem_reg[WORD_BITS-1:0], dvd_reg[NB-1]};
    assign trial = {1'b0, shifted} - {2'b00, den_reg};

    // run restoring division one bit a cycle
    always_comb
    begin
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctl.start)
        begin
            dvd_next  = {mag, FRAC_BITS'(0)};
            rem_next  = '0;
            den_next  = den;
            neg_next  = num[WORD_BITS+1];
            cnt_next  = CW'(NB);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[WORD_BITS+1])
            begin
                rem_next = trial[WORD_BITS:0];
                dvd_next = {dvd_reg[NB-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                dvd_next = {dvd_reg[NB-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    // saturate and apply sign
    logic [NB-1:0]        qmag;
    logic [WORD_BITS-1:0] qlim;
    assign qmag = (dvd_reg > limit) ? limit : dvd_reg;
    assign qlim = qmag[WORD_BITS-1:0];
    assign quo  = neg_reg ? $signed(~qlim + 1'b1) : $signed(qlim);
    assign sts.done = done_reg;
    assign sts.sat  = dvd_reg > limit;
endmodule
`default_nettype wire

>>> design/kbn_rot.sv
// Rotation degeneracy test: one shared multiplier stepped over six products.
// Compares the three cross-product term pairs exactly. Uses kbn_pkg.
`default_nettype none
module kbn_rot
    import kbn_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic signed [WORD_BITS-1:0] a0,
    input  wire logic signed [WORD_BITS-1:0] a1,
    input  wire logic signed [WORD_BITS-1:0] a2,
    input  wire logic signed [WORD_BITS-1:0] b0,
    input  wire logic signed [WORD_BITS-1:0] b1,
    input  wire logic signed [WORD_BITS-1:0] b2,
    output logic                           done,
    output logic                           degen
);
    localparam int PW = 2 * WORD_BITS;

    logic [2:0]              step_reg, step_next;
    logic                    busy_reg, busy_next;
    logic                    done_reg;
    logic                    eq_reg, eq_next;
    logic signed [PW-1:0]    prev_reg;
    logic signed [WORD_BITS-1:0] mx, my;
    logic signed [PW-1:0]    prod;

    // pick operands for this step: pairs (a1b2,a2b1),(a2b0,a0b2),(a0b1,a1b0)
    always_comb
    begin
        case (step_reg)
            3'd0: begin mx = a1; my = b2; end
            3'd1: begin mx = a2; my = b1; end
            3'd2: begin mx = a2; my = b0; end
            3'd3: begin mx = a0; my = b2; end
            3'd4: begin mx = a0; my = b1; end
            3'd5: begin mx = a1; my = b0; end
            default: begin mx = '0; my = '0; end
        endcase
    end
    assign prod = mx * my;

    always_comb
    begin
        step_next = step_reg;
        busy_next = busy_reg;
        eq_next   = eq_reg;
        if (start)
        begin
            step_next = '0;
            busy_next = 1'b1;
            eq_next   = 1'b1;
        end
        else if (busy_reg)
        begin
            if (step_reg[0] && prod != prev_reg)
                eq_next = 1'b0;
            step_next = step_reg + 1'b1;
            if (step_reg == 3'd5)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            eq_reg   <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= busy_reg && step_reg == 3'd5 && !start;
            eq_reg   <= eq_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prev_reg <= prod;
    end

    assign done  = done_reg;
    assign degen = eq_reg || (a0 == '0 && a1 == '0 && a2 == '0);
endmodule
`default_nettype wire
